// ----- rtl/rotated_box_to_aabb_top_macros.svh -----
// Assertion macros for the rotated box to bounding box block.
`ifndef ROTATED_BOX_TO_AABB_TOP_MACROS_SVH
`define ROTATED_BOX_TO_AABB_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rba_pkg.sv -----
// Types, constants and helper functions of the rotated box to bounding box block.
`default_nettype none

package rba_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;

  // CORDIC datapath widths: x/y in Q2.30 with headroom, angle in Q4.24
  localparam int XY_W = 34;
  localparam int Z_W  = 28;

  localparam logic signed [15:0]     ANGLE_LIMIT = 16'sd25736;
  localparam logic signed [Z_W-1:0]  HALF_PI_Q24 = 28'sd26353589;
  localparam logic signed [Z_W-1:0]  PI_Q24      = 28'sd52707179;
  localparam logic signed [XY_W-1:0] GAIN_Q30    = 34'sd652032875;

  typedef struct packed {
    logic signed [23:0] center_x;
    logic signed [23:0] center_y;
    logic        [22:0] box_w;
    logic        [22:0] box_h;
    logic signed [15:0] angle;
  } in_word_t;

  typedef struct packed {
    logic signed [23:0] left;
    logic signed [23:0] top;
    logic        [23:0] extent_x;
    logic        [23:0] extent_y;
  } out_word_t;

  // box geometry carried alongside the CORDIC
  typedef struct packed {
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic        [22:0] w;
    logic        [22:0] h;
  } geom_t;

  // arctangent of 2^-i in Q24
  function automatic logic signed [Z_W-1:0] atan_q24(input int idx);
    logic signed [Z_W-1:0] v;
    unique case (idx)
      0:  v = 28'sd13176795;
      1:  v = 28'sd7778716;
      2:  v = 28'sd4110060;
      3:  v = 28'sd2086331;
      4:  v = 28'sd1047214;
      5:  v = 28'sd524117;
      6:  v = 28'sd262123;
      7:  v = 28'sd131069;
      8:  v = 28'sd65536;
      9:  v = 28'sd32768;
      10: v = 28'sd16384;
      11: v = 28'sd8192;
      12: v = 28'sd4096;
      13: v = 28'sd2048;
      14: v = 28'sd1024;
      15: v = 28'sd512;
      16: v = 28'sd256;
      17: v = 28'sd128;
      18: v = 28'sd64;
      19: v = 28'sd32;
      20: v = 28'sd16;
      21: v = 28'sd8;
      22: v = 28'sd4;
      default: v = 28'sd2;
    endcase
    return v;
  endfunction

  // magnitude of a Q16 value, clamped to one
  function automatic logic [16:0] abs_unit(input logic signed [XY_W-1:0] v);
    logic [16:0] r;
    if (v >= 65536 || v <= -65536) begin
      r = 17'h10000;
    end else if (v < 0) begin
      r = 17'(-v);
    end else begin
      r = 17'(v);
    end
    return r;
  endfunction

  function automatic logic signed [23:0] sat_coord(input logic signed [25:0] v);
    logic signed [23:0] r;
    if (v > 26'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -26'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  function automatic logic [23:0] sat_extent(input logic signed [26:0] v);
    logic [23:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > 27'sd16777215) begin
      r = 24'hFFFFFF;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rotated_box_to_aabb_top.sv -----
// Top level: oriented box to axis-aligned bounding box, fully pipelined.
`default_nettype none

// Takes one oriented box word per cycle (center, width, height, angle in Q3.13
// radians) and returns its axis-aligned bounding box (left, top, extents) with
// Q8 coordinates, saturated to the field ranges. Throughput is one word per
// clock unless out_ready stalls. The pipe is one prep stage (angle clamp and
// fold into +-pi/2), one stage per CORDIC rotation step, then round, multiply,
// sum, corner and the output register. The CORDIC chain sets the depth. Every
// stage has a valid bit; a stall on out_ready only holds the occupied stages,
// so bubbles close up and in_ready stays high until the whole pipe is full.
// in_ready is low while rst_n is low. Angles beyond +-pi are clamped to +-pi.

`include "rotated_box_to_aabb_top_macros.svh"

module rotated_box_to_aabb_top
  import rba_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  // stage map: 0 prep, 1..N CORDIC steps, then round, multiply, sum, corner
  localparam int RND = CORDIC_STEPS + 1;
  localparam int MUL = CORDIC_STEPS + 2;
  localparam int SUM = CORDIC_STEPS + 3;
  localparam int CRN = CORDIC_STEPS + 4;
  localparam int NS  = CORDIC_STEPS + 5;

  logic [NS-1:0] v_r;
  logic [NS:0]   acc;     // stage takes a new word this cycle
  logic          out_valid_r;
  out_word_t     out_data_r;

  // -------------------------------------------------------------------------
  // Flow control: a stage loads when it is empty or its successor loads.
  // -------------------------------------------------------------------------
  always_comb begin
    acc[NS] = !out_valid_r || out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      acc[k] = !v_r[k] || acc[k+1];
    end
  end

  // no word is taken while reset holds the valid bits
  assign in_ready = acc[0] && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (acc[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
      if (acc[NS]) begin
        out_valid_r <= v_r[NS-1];
      end
    end
  end

  // -------------------------------------------------------------------------
  // Prep: clamp angle, scale to Q24, fold into +-pi/2 (fold negates cos/sin)
  // -------------------------------------------------------------------------
  logic signed [15:0]    ang_cl;
  logic signed [Z_W-1:0] z_raw;
  logic signed [Z_W-1:0] z_fold;
  logic                  flip_fold;

  always_comb begin
    if (in_data.angle > ANGLE_LIMIT) begin
      ang_cl = ANGLE_LIMIT;
    end else if (in_data.angle < -ANGLE_LIMIT) begin
      ang_cl = -ANGLE_LIMIT;
    end else begin
      ang_cl = in_data.angle;
    end
    z_raw = $signed({{(Z_W-27){ang_cl[15]}}, ang_cl, 11'b0});
    if (z_raw > HALF_PI_Q24) begin
      z_fold    = z_raw - PI_Q24;
      flip_fold = 1'b1;
    end else if (z_raw < -HALF_PI_Q24) begin
      z_fold    = z_raw + PI_Q24;
      flip_fold = 1'b1;
    end else begin
      z_fold    = z_raw;
      flip_fold = 1'b0;
    end
  end

  // -------------------------------------------------------------------------
  // CORDIC chain: stage k applies rotation step k-1
  // -------------------------------------------------------------------------
  logic signed [XY_W-1:0] x_r    [0:CORDIC_STEPS];
  logic signed [XY_W-1:0] y_r    [0:CORDIC_STEPS];
  logic signed [Z_W-1:0]  z_r    [0:CORDIC_STEPS];
  logic                   flip_r [0:CORDIC_STEPS];
  geom_t                  g_r    [0:CORDIC_STEPS];

  logic signed [XY_W-1:0] x_nxt  [1:CORDIC_STEPS];
  logic signed [XY_W-1:0] y_nxt  [1:CORDIC_STEPS];
  logic signed [Z_W-1:0]  z_nxt  [1:CORDIC_STEPS];

  always_comb begin
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    for (int k = 1; k <= CORDIC_STEPS; k++) begin
      // arithmetic shift floors, as the step needs
      xs = x_r[k-1] >>> (k - 1);
      ys = y_r[k-1] >>> (k - 1);
      if (z_r[k-1] >= 0) begin
        x_nxt[k] = x_r[k-1] - ys;
        y_nxt[k] = y_r[k-1] + xs;
        z_nxt[k] = z_r[k-1] - atan_q24(k - 1);
      end else begin
        x_nxt[k] = x_r[k-1] + ys;
        y_nxt[k] = y_r[k-1] - xs;
        z_nxt[k] = z_r[k-1] + atan_q24(k - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc[0]) begin
      x_r[0]    <= GAIN_Q30;
      y_r[0]    <= '0;
      z_r[0]    <= z_fold;
      flip_r[0] <= flip_fold;
      g_r[0]    <= '{cx: in_data.center_x, cy: in_data.center_y,
                     w: in_data.box_w, h: in_data.box_h};
    end
    for (int k = 1; k <= CORDIC_STEPS; k++) begin
      if (acc[k]) begin
        x_r[k]    <= x_nxt[k];
        y_r[k]    <= y_nxt[k];
        z_r[k]    <= z_nxt[k];
        flip_r[k] <= flip_r[k-1];
        g_r[k]    <= g_r[k-1];
      end
    end
  end

  // -------------------------------------------------------------------------
  // Round: unfold sign, round to Q16 half up, keep clamped magnitudes.
  // Only |cos| and |sin| matter: the extreme corners use |w*c| + |h*s|.
  // -------------------------------------------------------------------------
  logic signed [XY_W-1:0] xf, yf, xq, yq;
  logic [16:0]            ac_r, as_r;
  geom_t                  g_rnd_r;

  always_comb begin
    xf = flip_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
    yf = flip_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];
    xq = (xf + XY_W'(8192)) >>> 14;
    yq = (yf + XY_W'(8192)) >>> 14;
  end

  always_ff @(posedge clk) begin
    if (acc[RND]) begin
      ac_r    <= abs_unit(xq);
      as_r    <= abs_unit(yq);
      g_rnd_r <= g_r[CORDIC_STEPS];
    end
  end

  // -------------------------------------------------------------------------
  // Multiply: four half-size products in Q25 (size is Q9 half, trig Q16)
  // -------------------------------------------------------------------------
  logic [39:0]        pwc_r, phs_r, pws_r, phc_r;
  logic signed [23:0] cx_mul_r, cy_mul_r;

  always_ff @(posedge clk) begin
    if (acc[MUL]) begin
      pwc_r    <= {17'b0, g_rnd_r.w} * {23'b0, ac_r};
      phs_r    <= {17'b0, g_rnd_r.h} * {23'b0, as_r};
      pws_r    <= {17'b0, g_rnd_r.w} * {23'b0, as_r};
      phc_r    <= {17'b0, g_rnd_r.h} * {23'b0, ac_r};
      cx_mul_r <= g_rnd_r.cx;
      cy_mul_r <= g_rnd_r.cy;
    end
  end

  // -------------------------------------------------------------------------
  // Sum: half extents of the bounding box in Q25
  // -------------------------------------------------------------------------
  logic [40:0]        hx_r, hy_r;
  logic signed [23:0] cx_sum_r, cy_sum_r;

  always_ff @(posedge clk) begin
    if (acc[SUM]) begin
      hx_r     <= {1'b0, pwc_r} + {1'b0, phs_r};
      hy_r     <= {1'b0, pws_r} + {1'b0, phc_r};
      cx_sum_r <= cx_mul_r;
      cy_sum_r <= cy_mul_r;
    end
  end

  // -------------------------------------------------------------------------
  // Corner: min/max = center -/+ half extent, rounded to Q8 half up.
  // Rounding is monotone, so rounding the extremes equals extremes of rounded.
  // -------------------------------------------------------------------------
  logic signed [42:0] cxs, cys, lo_x, hi_x, lo_y, hi_y;
  logic signed [25:0] minx_r, maxx_r, miny_r, maxy_r;

  always_comb begin
    cxs  = $signed({{2{cx_sum_r[23]}}, cx_sum_r, 17'b0}) + 43'sd65536;
    cys  = $signed({{2{cy_sum_r[23]}}, cy_sum_r, 17'b0}) + 43'sd65536;
    lo_x = cxs - $signed({2'b0, hx_r});
    hi_x = cxs + $signed({2'b0, hx_r});
    lo_y = cys - $signed({2'b0, hy_r});
    hi_y = cys + $signed({2'b0, hy_r});
  end

  always_ff @(posedge clk) begin
    if (acc[CRN]) begin
      minx_r <= $signed(lo_x[42:17]);
      maxx_r <= $signed(hi_x[42:17]);
      miny_r <= $signed(lo_y[42:17]);
      maxy_r <= $signed(hi_y[42:17]);
    end
  end

  // -------------------------------------------------------------------------
  // Output: saturate and register
  // -------------------------------------------------------------------------
  logic signed [26:0] ext_x, ext_y;

  always_comb begin
    ext_x = $signed({maxx_r[25], maxx_r}) - $signed({minx_r[25], minx_r});
    ext_y = $signed({maxy_r[25], maxy_r}) - $signed({miny_r[25], miny_r});
  end

  always_ff @(posedge clk) begin
    if (acc[NS]) begin
      out_data_r <= '{left: sat_coord(minx_r), top: sat_coord(miny_r),
                      extent_x: sat_extent(ext_x), extent_y: sat_extent(ext_y)};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `RBA_ASSERT_NOW(a_full_when_blocked, !in_ready, (&v_r) && out_valid_r && !out_ready, "input blocked with a free stage")
  `RBA_ASSERT_NEXT(a_tail_held, v_r[CRN] && !acc[NS], v_r[CRN] && $stable(minx_r), "stalled tail word lost")
  `RBA_ASSERT_NOW(a_trig_bound, v_r[RND], ac_r <= 17'h10000 && as_r <= 17'h10000, "trig magnitude above one")
  `RBA_ASSERT_NOW(a_corner_order, v_r[CRN], minx_r <= maxx_r && miny_r <= maxy_r, "min corner beyond max corner")

endmodule

`default_nettype wire
